// ===== rtl/tti_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and blend arithmetic of the trilinear table interpolator.
package tti_pkg;

    localparam int DATA_W   = 32;
    localparam int CHANNELS = 4;
    localparam int FRAC_W   = 12;
    localparam int CELL_W   = 5;
    localparam int ADDR_W   = 12;
    localparam int IDX_W    = 15;
    localparam int STRAIN_W = 16;
    localparam int COORD_W  = 24;
    localparam int CORNERS  = 8;
    localparam int CORNER_W = 3;
    localparam int QUARTER  = 1024;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef logic [DATA_W-1:0] word_t;
    typedef word_t [CHANNELS-1:0] sample_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [FRAC_W-1:0] frac_t;

    typedef struct packed {
        cmd_t                      cmd;
        logic                      wen;
        logic [CORNER_W-1:0]       wbank;
        addr_t [CORNERS-1:0]       addr;
        sample_t                   data;
        logic [CORNER_W-1:0]       par;
        frac_t                     af;
        frac_t                     bf;
        frac_t                     cf;
    } job_t;

    function automatic word_t lerp(input word_t v0, input word_t v1, input frac_t f);
        logic signed [DATA_W:0]            diff;
        logic signed [DATA_W+FRAC_W+1:0]   prod;
        logic signed [DATA_W:0]            step;
        diff = $signed({1'b0, v1}) - $signed({1'b0, v0});
        prod = diff * $signed({1'b0, f});
        step = prod[FRAC_W +: DATA_W+1];
        return v0 + step[DATA_W-1:0];
    endfunction

endpackage

// ===== rtl/tti_fifo.sv =====
`timescale 1ns / 1ps
// Small first-in first-out queue with registered storage.
module tti_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW:0]      wr_ptr_reg;
    logic [PW:0]      wr_ptr_next;
    logic [PW:0]      rd_ptr_reg;
    logic [PW:0]      rd_ptr_next;

    assign empty = (wr_ptr_reg == rd_ptr_reg);
    assign full  = (wr_ptr_reg[PW] != rd_ptr_reg[PW]) &&
                   (wr_ptr_reg[PW-1:0] == rd_ptr_reg[PW-1:0]);
    assign dout  = mem[rd_ptr_reg[PW-1:0]];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push && !full)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop && !empty)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem[wr_ptr_reg[PW-1:0]] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

endmodule

// ===== rtl/tti_front.sv =====
`timescale 1ns / 1ps
// Front end: accept beats, split load indexes and map query strains to bank addresses.
module tti_front #(
    parameter int GRID_SIZE = 30,
    parameter int MQ_DEPTH  = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic                                 cmd,
    input  logic [tti_pkg::IDX_W-1:0]            entry_index,
    input  tti_pkg::sample_t                     samples,
    input  logic signed [tti_pkg::STRAIN_W-1:0]  strain_uu,
    input  logic signed [tti_pkg::STRAIN_W-1:0]  strain_vv,
    input  logic signed [tti_pkg::STRAIN_W-1:0]  strain_uv,
    output logic                                 job_valid,
    output tti_pkg::job_t                        job,
    input  logic                                 job_pop
);

    localparam int IDX_W    = tti_pkg::IDX_W;
    localparam int CELL_W   = tti_pkg::CELL_W;
    localparam int FRAC_W   = tti_pkg::FRAC_W;
    localparam int ADDR_W   = tti_pkg::ADDR_W;
    localparam int COORD_W  = tti_pkg::COORD_W;
    localparam int STRAIN_W = tti_pkg::STRAIN_W;
    localparam int MUL_W    = 40;
    localparam int GG       = GRID_SIZE * GRID_SIZE;
    localparam int G3       = GG * GRID_SIZE;
    localparam int HALF     = (GRID_SIZE + 1) / 2;
    localparam int HH       = HALF * HALF;
    localparam int L1       = $clog2(GG);
    localparam int S1       = IDX_W + L1;
    localparam longint M1   = ((longint'(1) << S1) + GG - 1) / GG;
    localparam int L2       = $clog2(GRID_SIZE);
    localparam int S2       = IDX_W + L2;
    localparam longint M2   = ((longint'(1) << S2) + GRID_SIZE - 1) / GRID_SIZE;
    localparam int CNT_W    = $clog2(MQ_DEPTH + 1);
    localparam logic [COORD_W-1:0] G_C = COORD_W'(GRID_SIZE);
    localparam logic [COORD_W-1:0] TOP = COORD_W'((GRID_SIZE - 1) * (1 << FRAC_W) - 1);

    function automatic logic [CELL_W+FRAC_W-1:0] clamp_coord(input logic [COORD_W-1:0] q);
        logic [COORD_W-1:0] c;
        if (q[COORD_W-1])
        begin
            c = '0;
        end
        else if (q > TOP)
        begin
            c = TOP;
        end
        else
        begin
            c = q;
        end
        return c[CELL_W+FRAC_W-1:0];
    endfunction

    logic             accept;
    logic [CNT_W-1:0] fill_cnt_reg;
    logic [CNT_W-1:0] fill_cnt_next;

    logic [MUL_W-1:0]   qi_prod;
    logic [COORD_W-1:0] uu_ext;
    logic [COORD_W-1:0] vv_ext;
    logic [COORD_W-1:0] uv_ext;
    logic [COORD_W-1:0] uv_abs;

    logic                        s1_valid_reg;
    tti_pkg::cmd_t               s1_cmd_reg;
    logic                        s1_ok_reg;
    logic [IDX_W-1:0]            s1_idx_reg;
    logic [CELL_W-1:0]           s1_qi_reg;
    tti_pkg::sample_t            s1_data_reg;
    logic [COORD_W-1:0]          s1_ca_reg;
    logic [COORD_W-1:0]          s1_cb_reg;
    logic [COORD_W-1:0]          s1_cc_reg;

    logic [IDX_W-1:0]            rem;
    logic [CELL_W+FRAC_W-1:0]    qa;
    logic [CELL_W+FRAC_W-1:0]    qb;
    logic [CELL_W+FRAC_W-1:0]    qc;

    logic                        s2_valid_reg;
    tti_pkg::cmd_t               s2_cmd_reg;
    logic                        s2_ok_reg;
    logic [CELL_W-1:0]           s2_qi_reg;
    logic [IDX_W-1:0]            s2_rem_reg;
    tti_pkg::sample_t            s2_data_reg;
    logic [CELL_W-1:0]           s2_ai_reg;
    logic [CELL_W-1:0]           s2_bi_reg;
    logic [CELL_W-1:0]           s2_ci_reg;
    tti_pkg::frac_t              s2_af_reg;
    tti_pkg::frac_t              s2_bf_reg;
    tti_pkg::frac_t              s2_cf_reg;

    logic [MUL_W-1:0]            qj_prod;
    tti_pkg::addr_t              ti [2];
    tti_pkg::addr_t              tj [2];
    tti_pkg::addr_t              tk [2];
    tti_pkg::addr_t              tl;

    logic                        s3_valid_reg;
    tti_pkg::cmd_t               s3_cmd_reg;
    logic                        s3_ok_reg;
    logic                        s3_qi0_reg;
    logic [CELL_W-1:0]           s3_qj_reg;
    logic [IDX_W-1:0]            s3_rem_reg;
    tti_pkg::addr_t              s3_tl_reg;
    tti_pkg::addr_t              s3_ti_reg [2];
    tti_pkg::addr_t              s3_tj_reg [2];
    tti_pkg::addr_t              s3_tk_reg [2];
    tti_pkg::sample_t            s3_data_reg;
    logic [tti_pkg::CORNER_W-1:0] s3_par_reg;
    tti_pkg::frac_t              s3_af_reg;
    tti_pkg::frac_t              s3_bf_reg;
    tti_pkg::frac_t              s3_cf_reg;

    logic [IDX_W-1:0]            k_full;
    logic [CELL_W-1:0]           k;
    tti_pkg::addr_t              waddr;

    assign accept = push && !full;
    assign full   = (fill_cnt_reg >= CNT_W'(MQ_DEPTH));

    always_comb
    begin
        fill_cnt_next = fill_cnt_reg + CNT_W'(accept) - CNT_W'(job_pop);
    end

    // Stage 1: plane quotient and scaled coordinates.
    always_comb
    begin
        qi_prod = MUL_W'(entry_index) * MUL_W'(M1);
        uu_ext  = {{(COORD_W-STRAIN_W){strain_uu[STRAIN_W-1]}}, strain_uu};
        vv_ext  = {{(COORD_W-STRAIN_W){strain_vv[STRAIN_W-1]}}, strain_vv};
        uv_ext  = {{(COORD_W-STRAIN_W){strain_uv[STRAIN_W-1]}}, strain_uv};
        uv_abs  = uv_ext[COORD_W-1] ? (COORD_W'(0) - uv_ext) : uv_ext;
    end

    always_ff @(posedge clk)
    begin
        s1_cmd_reg  <= tti_pkg::cmd_t'(cmd);
        s1_ok_reg   <= ({1'b0, entry_index} < (IDX_W+1)'(G3));
        s1_idx_reg  <= entry_index;
        s1_qi_reg   <= qi_prod[S1 +: CELL_W];
        s1_data_reg <= samples;
        s1_ca_reg   <= (uu_ext + COORD_W'(tti_pkg::QUARTER)) * G_C;
        s1_cb_reg   <= (vv_ext + COORD_W'(tti_pkg::QUARTER)) * G_C;
        s1_cc_reg   <= uv_abs * G_C;
    end

    // Stage 2: row remainder, clamp and split.
    always_comb
    begin
        rem = s1_idx_reg - IDX_W'(IDX_W'(s1_qi_reg) * IDX_W'(GG));
        qa  = clamp_coord(s1_ca_reg);
        qb  = clamp_coord(s1_cb_reg);
        qc  = clamp_coord(s1_cc_reg);
    end

    always_ff @(posedge clk)
    begin
        s2_cmd_reg  <= s1_cmd_reg;
        s2_ok_reg   <= s1_ok_reg;
        s2_qi_reg   <= s1_qi_reg;
        s2_rem_reg  <= rem;
        s2_data_reg <= s1_data_reg;
        s2_ai_reg   <= qa[FRAC_W +: CELL_W];
        s2_bi_reg   <= qb[FRAC_W +: CELL_W];
        s2_ci_reg   <= qc[FRAC_W +: CELL_W];
        s2_af_reg   <= qa[FRAC_W-1:0];
        s2_bf_reg   <= qb[FRAC_W-1:0];
        s2_cf_reg   <= qc[FRAC_W-1:0];
    end

    // Stage 3: row quotient and per-parity address terms.
    always_comb
    begin
        qj_prod = MUL_W'(s2_rem_reg) * MUL_W'(M2);
        ti[0] = (ADDR_W'(s2_ai_reg[CELL_W-1:1]) + ADDR_W'(s2_ai_reg[0])) * ADDR_W'(HH);
        ti[1] = ADDR_W'(s2_ai_reg[CELL_W-1:1]) * ADDR_W'(HH);
        tj[0] = (ADDR_W'(s2_bi_reg[CELL_W-1:1]) + ADDR_W'(s2_bi_reg[0])) * ADDR_W'(HALF);
        tj[1] = ADDR_W'(s2_bi_reg[CELL_W-1:1]) * ADDR_W'(HALF);
        tk[0] = ADDR_W'(s2_ci_reg[CELL_W-1:1]) + ADDR_W'(s2_ci_reg[0]);
        tk[1] = ADDR_W'(s2_ci_reg[CELL_W-1:1]);
        tl    = ADDR_W'(s2_qi_reg[CELL_W-1:1]) * ADDR_W'(HH);
    end

    always_ff @(posedge clk)
    begin
        s3_cmd_reg    <= s2_cmd_reg;
        s3_ok_reg     <= s2_ok_reg;
        s3_qi0_reg    <= s2_qi_reg[0];
        s3_qj_reg     <= qj_prod[S2 +: CELL_W];
        s3_rem_reg    <= s2_rem_reg;
        s3_tl_reg     <= tl;
        s3_ti_reg     <= ti;
        s3_tj_reg     <= tj;
        s3_tk_reg     <= tk;
        s3_data_reg   <= s2_data_reg;
        s3_par_reg    <= {s2_ai_reg[0], s2_bi_reg[0], s2_ci_reg[0]};
        s3_af_reg     <= s2_af_reg;
        s3_bf_reg     <= s2_bf_reg;
        s3_cf_reg     <= s2_cf_reg;
    end

    // Stage 4: column, bank and final addresses.
    always_comb
    begin
        k_full    = s3_rem_reg - IDX_W'(IDX_W'(s3_qj_reg) * IDX_W'(GRID_SIZE));
        k         = k_full[CELL_W-1:0];
        waddr     = s3_tl_reg + ADDR_W'(s3_qj_reg[CELL_W-1:1]) * ADDR_W'(HALF)
                    + ADDR_W'(k[CELL_W-1:1]);
        job.cmd   = s3_cmd_reg;
        job.wen   = s3_ok_reg;
        job.wbank = {s3_qi0_reg, s3_qj_reg[0], k[0]};
        job.data  = s3_data_reg;
        job.par   = s3_par_reg;
        job.af    = s3_af_reg;
        job.bf    = s3_bf_reg;
        job.cf    = s3_cf_reg;
        for (int b = 0; b < tti_pkg::CORNERS; b++)
        begin
            if (s3_cmd_reg == tti_pkg::CMD_LOAD)
            begin
                job.addr[b] = waddr;
            end
            else
            begin
                job.addr[b] = s3_ti_reg[b[2]] + s3_tj_reg[b[1]] + s3_tk_reg[b[0]];
            end
        end
    end

    assign job_valid = s3_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            fill_cnt_reg <= '0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            fill_cnt_reg <= fill_cnt_next;
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_cnt_reg <= CNT_W'(MQ_DEPTH))
        else $error("front fill count exceeds queue depth");

    a_fill_covers_stages: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> fill_cnt_reg != '0)
        else $error("beat in flight not counted");

endmodule

// ===== rtl/tti_back.sv =====
`timescale 1ns / 1ps
// Back end: banked sample grid and the three-step trilinear blend.
module tti_back #(
    parameter int GRID_SIZE = 30,
    parameter int OQ_DEPTH  = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  tti_pkg::job_t    job,
    input  logic             job_empty,
    output logic             job_pop,
    output logic             res_push,
    output tti_pkg::sample_t res,
    input  logic             res_pop
);

    localparam int HALF       = (GRID_SIZE + 1) / 2;
    localparam int BANK_DEPTH = HALF * HALF * HALF;
    localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int CR_W       = $clog2(OQ_DEPTH + 1);
    localparam int CORNERS    = tti_pkg::CORNERS;
    localparam int CORNER_W   = tti_pkg::CORNER_W;
    localparam int CHANNELS   = tti_pkg::CHANNELS;

    logic            qpop;
    logic [CR_W-1:0] credit_reg;
    logic [CR_W-1:0] credit_next;

    tti_pkg::sample_t            rd_reg [CORNERS];
    logic                        s1_valid_reg;
    logic [CORNER_W-1:0]         s1_par_reg;
    tti_pkg::frac_t              s1_af_reg;
    tti_pkg::frac_t              s1_bf_reg;
    tti_pkg::frac_t              s1_cf_reg;

    tti_pkg::sample_t            x1 [CORNERS];
    tti_pkg::sample_t            x2 [CORNERS];
    tti_pkg::sample_t            x3 [CORNERS];
    tti_pkg::sample_t            edge_lerp [4];

    logic                        s2_valid_reg;
    tti_pkg::sample_t            s2_r_reg [4];
    tti_pkg::frac_t              s2_af_reg;
    tti_pkg::frac_t              s2_bf_reg;

    tti_pkg::sample_t            plane [2];

    logic                        s3_valid_reg;
    tti_pkg::sample_t            s3_plane_reg [2];
    tti_pkg::frac_t              s3_af_reg;

    assign job_pop = !job_empty &&
                     ((job.cmd == tti_pkg::CMD_LOAD) || (credit_reg < CR_W'(OQ_DEPTH)));
    assign qpop    = job_pop && (job.cmd == tti_pkg::CMD_QUERY);

    always_comb
    begin
        credit_next = credit_reg + CR_W'(qpop) - CR_W'(res_pop);
    end

    for (genvar b = 0; b < CORNERS; b++)
    begin : bank_g
        tti_pkg::sample_t mem [BANK_DEPTH];
        logic             we;

        assign we = job_pop && (job.cmd == tti_pkg::CMD_LOAD) && job.wen &&
                    (job.wbank == CORNER_W'(b));

        always_ff @(posedge clk)
        begin
            if (we)
            begin
                mem[job.addr[b][AW-1:0]] <= job.data;
            end
            rd_reg[b] <= mem[job.addr[b][AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        s1_par_reg <= job.par;
        s1_af_reg  <= job.af;
        s1_bf_reg  <= job.bf;
        s1_cf_reg  <= job.cf;
    end

    // Undo the bank parity permutation, then blend along the third axis.
    always_comb
    begin
        for (int d = 0; d < CORNERS; d++)
        begin
            x1[d] = s1_par_reg[0] ? rd_reg[CORNER_W'(d ^ 1)] : rd_reg[d];
        end
        for (int d = 0; d < CORNERS; d++)
        begin
            x2[d] = s1_par_reg[1] ? x1[CORNER_W'(d ^ 2)] : x1[d];
        end
        for (int d = 0; d < CORNERS; d++)
        begin
            x3[d] = s1_par_reg[2] ? x2[CORNER_W'(d ^ 4)] : x2[d];
        end
        for (int p = 0; p < 4; p++)
        begin
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                edge_lerp[p][ch] = tti_pkg::lerp(x3[2*p][ch], x3[2*p+1][ch], s1_cf_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s2_r_reg  <= edge_lerp;
        s2_af_reg <= s1_af_reg;
        s2_bf_reg <= s1_bf_reg;
    end

    always_comb
    begin
        for (int di = 0; di < 2; di++)
        begin
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                plane[di][ch] = tti_pkg::lerp(s2_r_reg[2*di][ch], s2_r_reg[2*di+1][ch],
                                              s2_bf_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s3_plane_reg <= plane;
        s3_af_reg    <= s2_af_reg;
    end

    always_comb
    begin
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            res[ch] = tti_pkg::lerp(s3_plane_reg[0][ch], s3_plane_reg[1][ch], s3_af_reg);
        end
    end

    assign res_push = s3_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            credit_reg   <= '0;
        end
        else
        begin
            s1_valid_reg <= qpop;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            credit_reg   <= credit_next;
        end
    end

    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        credit_reg <= CR_W'(OQ_DEPTH))
        else $error("result credits exceed output queue depth");

    a_result_counted: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> credit_reg != '0)
        else $error("result in flight without a credit");

endmodule

// ===== rtl/trilinear_table_interpolator.sv =====
`timescale 1ns / 1ps
// Top level of the trilinear table interpolator.
//
// Input queue side: drive push with one beat; it is taken on a clock edge
// where push is high and full is low. cmd low loads the four samples at
// entry_index into the grid (no result; an index past the grid is dropped).
// cmd high queries with the three strain terms and yields one result beat.
// Result queue side: while empty is low, stiff_ch0..3 show the oldest result;
// it leaves on a clock edge where pop is high.
// A query result passes through the 3 decode stages, the decode queue,
// the registered bank read, 2 blend stages and the result queue before it
// is visible. Throughput: one beat per cycle while full is low, loads and
// queries mixed; the eight grid banks deliver all corners of a cell in one read.
// A load is visible to every query taken after it.
// Reset clears the queues and pipeline; grid contents stay undefined until
// loaded. When pop is held low the result queue fills, queries stop issuing
// to the grid, the decode queue backs up and full rises; no beat is lost.
module trilinear_table_interpolator #(
    parameter int GRID_SIZE = 30
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic                                 cmd,
    input  logic [tti_pkg::IDX_W-1:0]            entry_index,
    input  logic [tti_pkg::DATA_W-1:0]           sample_ch0,
    input  logic [tti_pkg::DATA_W-1:0]           sample_ch1,
    input  logic [tti_pkg::DATA_W-1:0]           sample_ch2,
    input  logic [tti_pkg::DATA_W-1:0]           sample_ch3,
    input  logic signed [tti_pkg::STRAIN_W-1:0]  strain_uu,
    input  logic signed [tti_pkg::STRAIN_W-1:0]  strain_vv,
    input  logic signed [tti_pkg::STRAIN_W-1:0]  strain_uv,
    output logic                                 empty,
    input  logic                                 pop,
    output logic [tti_pkg::DATA_W-1:0]           stiff_ch0,
    output logic [tti_pkg::DATA_W-1:0]           stiff_ch1,
    output logic [tti_pkg::DATA_W-1:0]           stiff_ch2,
    output logic [tti_pkg::DATA_W-1:0]           stiff_ch3
);

    localparam int MQ_DEPTH = 8;
    localparam int OQ_DEPTH = 8;

    tti_pkg::sample_t in_samples;
    logic             job_valid;
    tti_pkg::job_t    job_in;
    tti_pkg::job_t    job_head;
    logic             mq_full;
    logic             mq_empty;
    logic             job_pop;
    logic             res_push;
    tti_pkg::sample_t res;
    tti_pkg::sample_t res_head;
    logic             oq_full;
    logic             res_pop;

    assign in_samples = {sample_ch3, sample_ch2, sample_ch1, sample_ch0};
    assign res_pop    = pop && !empty;

    tti_front #(
        .GRID_SIZE (GRID_SIZE),
        .MQ_DEPTH  (MQ_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .cmd         (cmd),
        .entry_index (entry_index),
        .samples     (in_samples),
        .strain_uu   (strain_uu),
        .strain_vv   (strain_vv),
        .strain_uv   (strain_uv),
        .job_valid   (job_valid),
        .job         (job_in),
        .job_pop     (job_pop)
    );

    tti_fifo #(
        .WIDTH ($bits(tti_pkg::job_t)),
        .DEPTH (MQ_DEPTH)
    ) u_job_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_valid),
        .din   (job_in),
        .full  (mq_full),
        .pop   (job_pop),
        .dout  (job_head),
        .empty (mq_empty)
    );

    tti_back #(
        .GRID_SIZE (GRID_SIZE),
        .OQ_DEPTH  (OQ_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job_head),
        .job_empty (mq_empty),
        .job_pop   (job_pop),
        .res_push  (res_push),
        .res       (res),
        .res_pop   (res_pop)
    );

    tti_fifo #(
        .WIDTH ($bits(tti_pkg::sample_t)),
        .DEPTH (OQ_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res),
        .full  (oq_full),
        .pop   (pop),
        .dout  (res_head),
        .empty (empty)
    );

    assign stiff_ch0 = res_head[0];
    assign stiff_ch1 = res_head[1];
    assign stiff_ch2 = res_head[2];
    assign stiff_ch3 = res_head[3];

    a_job_q_room: assert property (@(posedge clk) disable iff (!rst_n)
        !(job_valid && mq_full))
        else $error("decode queue overflow");

    a_res_q_room: assert property (@(posedge clk) disable iff (!rst_n)
        !(res_push && oq_full))
        else $error("result queue overflow");

endmodule
